@@ design/rhsl_pkg.sv @@
// Shared constants and types for the RGB to HSL converter.
// No dependencies; compiled first.
package rhsl_pkg;

  localparam int FRAC_BITS = 12;
  localparam int ONE       = 1 << FRAC_BITS;
  localparam int CH_W      = FRAC_BITS + 1;   // channel and result width
  localparam int SUM_W     = CH_W + 1;        // max + min
  localparam int DEN_W     = CH_W + 3;        // holds 6 * spread
  localparam int Q_W       = FRAC_BITS + 1;   // quotient bits before saturation
  localparam int DIV_STEPS = Q_W;             // one quotient bit per stage

  typedef enum logic [1:0] {
    DOM_RED,
    DOM_GREEN,
    DOM_BLUE
  } dom_t;

  // side data that rides alongside the dividers
  typedef struct packed {
    logic            gray;
    logic            sat_force;
    logic [CH_W-1:0] light;
  } sb_t;

endpackage

@@ design/rhsl_rgb_if.sv @@
// Pixel channel interfaces: RGB beats in, HSL beats out.
// Depends on rhsl_pkg.
interface rhsl_rgb_if;
  import rhsl_pkg::*;
  logic            valid;
  logic            ready;
  logic [CH_W-1:0] red;
  logic [CH_W-1:0] green;
  logic [CH_W-1:0] blue;
  modport source (output valid, output red, output green, output blue, input ready);
  modport sink   (input valid, input red, input green, input blue, output ready);
endinterface

interface rhsl_hsl_if;
  import rhsl_pkg::*;
  logic            valid;
  logic            ready;
  logic [CH_W-1:0] hue;
  logic [CH_W-1:0] saturation;
  logic [CH_W-1:0] lightness;
  modport source (output valid, output hue, output saturation, output lightness,
                  input ready);
  modport sink   (input valid, input hue, input saturation, input lightness,
                  output ready);
endinterface

@@ design/rhsl_div.sv @@
// Pipelined restoring divider, one quotient bit per stage.
// Depends on rhsl_pkg. Caller guarantees num < 2 * den.
module rhsl_div (
  input  logic                             clk,
  input  logic [rhsl_pkg::DIV_STEPS-1:0]   en,
  input  logic [rhsl_pkg::DEN_W-1:0]       num,
  input  logic [rhsl_pkg::DEN_W-1:0]       den,
  output logic [rhsl_pkg::Q_W-1:0]         quo
);
  import rhsl_pkg::*;

  logic [DEN_W-1:0] rem   [DIV_STEPS];
  logic [DEN_W-1:0] dv    [DIV_STEPS];
  logic [Q_W-1:0]   q     [DIV_STEPS];
  logic [DEN_W-1:0] rem_next [DIV_STEPS];
  logic [DEN_W-1:0] dv_next  [DIV_STEPS];
  logic [Q_W-1:0]   q_next   [DIV_STEPS];

  always_comb begin
    for (int j = 0; j < DIV_STEPS; j++) begin
      logic [DEN_W:0]   r_in;
      logic [DEN_W-1:0] d_in;
      logic [Q_W-1:0]   q_in;
      logic             ge;
      if (j == 0) begin
        r_in = {1'b0, num};
        d_in = den;
        q_in = '0;
      end else begin
        r_in = {rem[j-1], 1'b0};
        d_in = dv[j-1];
        q_in = q[j-1];
      end
      ge = r_in >= {1'b0, d_in};
      rem_next[j] = ge ? DEN_W'(r_in - {1'b0, d_in}) : DEN_W'(r_in);
      dv_next[j]  = d_in;
      q_next[j]   = q_in;
      q_next[j][Q_W-1-j] = ge;
    end
  end

  always_ff @(posedge clk) begin
    for (int j = 0; j < DIV_STEPS; j++) begin
      if (en[j]) begin
        rem[j] <= rem_next[j];
        dv[j]  <= dv_next[j];
        q[j]   <= q_next[j];
      end
    end
  end

  assign quo = q[DIV_STEPS-1];

endmodule

@@ design/rgb_to_hsl_converter.sv @@
// RGB to HSL conversion, Q12 fixed point, fully pipelined.
// Depends on rhsl_pkg, rhsl_rgb_if, rhsl_hsl_if and rhsl_div.
//
// Takes one pixel per clock while the output is not stalled and returns one HSL result per pixel, in order.
// On the way from an accepted beat to its valid result,
// four stages find max/min, spread, sum and the divider operands, two
// 13-stage restoring dividers (one for hue, one for saturation, one quotient
// bit per stage) do the divisions, and a final stage saturates into the
// output register. Every stage has its own valid bit and advances when the
// stage after it is empty or moving, so a stalled output only stops the
// beats behind it and empty stages keep filling.
module rgb_to_hsl_converter (
  input logic       clk,
  input logic       rst,
  rhsl_rgb_if.sink  rgb,
  rhsl_hsl_if.source hsl
);
  import rhsl_pkg::*;

  localparam int ST_A    = 0;
  localparam int ST_B    = 1;
  localparam int ST_C    = 2;
  localparam int ST_D    = 3;
  localparam int ST_DIV0 = 4;
  localparam int ST_OUT  = ST_DIV0 + DIV_STEPS;
  localparam int NST     = ST_OUT + 1;

  localparam logic [SUM_W-1:0] ONE_S     = SUM_W'(ONE);
  localparam logic [SUM_W-1:0] TWO_ONE_S = SUM_W'(2 * ONE);
  localparam logic [CH_W-1:0]  ONE_C     = CH_W'(ONE);

  logic [NST-1:0] v;
  logic [NST-1:0] en;

  // per-stage advance: a stage loads when it is empty or its successor loads
  always_comb begin
    en[NST-1] = !v[NST-1] || hsl.ready;
    for (int i = NST - 2; i >= 0; i--) begin
      en[i] = !v[i] || en[i+1];
    end
  end

  assign rgb.ready = en[ST_A];

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      if (en[0]) v[0] <= rgb.valid;
      for (int i = 1; i < NST; i++) begin
        if (en[i]) v[i] <= v[i-1];
      end
    end
  end

  // stage A: extremes, dominant channel, pairwise differences
  logic [CH_W-1:0]   s0_mx, s0_mn;
  dom_t              s0_dom;
  logic signed [CH_W:0] s0_gb, s0_br, s0_rg;

  logic [CH_W-1:0] mx_rg, mn_rg, mx_a, mn_a;
  dom_t            dom_a;

  always_comb begin
    mx_rg = (rgb.red > rgb.green) ? rgb.red : rgb.green;
    mn_rg = (rgb.red < rgb.green) ? rgb.red : rgb.green;
    mx_a  = (rgb.blue > mx_rg) ? rgb.blue : mx_rg;
    mn_a  = (rgb.blue < mn_rg) ? rgb.blue : mn_rg;
    if (rgb.red == mx_a)        dom_a = DOM_RED;
    else if (rgb.green == mx_a) dom_a = DOM_GREEN;
    else                        dom_a = DOM_BLUE;
  end

  always_ff @(posedge clk) begin
    if (en[ST_A]) begin
      s0_mx  <= mx_a;
      s0_mn  <= mn_a;
      s0_dom <= dom_a;
      s0_gb  <= $signed({1'b0, rgb.green}) - $signed({1'b0, rgb.blue});
      s0_br  <= $signed({1'b0, rgb.blue}) - $signed({1'b0, rgb.red});
      s0_rg  <= $signed({1'b0, rgb.red}) - $signed({1'b0, rgb.green});
    end
  end

  // stage B: sum and spread
  logic [SUM_W-1:0]     s1_sum;
  logic [CH_W-1:0]      s1_d;
  logic                 s1_gray;
  dom_t                 s1_dom;
  logic signed [CH_W:0] s1_gb, s1_br, s1_rg;

  always_ff @(posedge clk) begin
    if (en[ST_B]) begin
      s1_sum  <= SUM_W'(s0_mx) + SUM_W'(s0_mn);
      s1_d    <= s0_mx - s0_mn;
      s1_gray <= s0_mx == s0_mn;
      s1_dom  <= s0_dom;
      s1_gb   <= s0_gb;
      s1_br   <= s0_br;
      s1_rg   <= s0_rg;
    end
  end

  // stage C: hue numerator and divisor, saturation divisor, lightness
  logic [DEN_W-1:0] d6_c, num_c;
  logic [CH_W-1:0]  sden_c, light_c;
  logic [SUM_W-2:0] half_c;

  always_comb begin
    logic signed [DEN_W:0] gb_x, br_x, rg_x, t;
    gb_x = (DEN_W+1)'(s1_gb);
    br_x = (DEN_W+1)'(s1_br);
    rg_x = (DEN_W+1)'(s1_rg);
    d6_c = (DEN_W'(s1_d) << 2) + (DEN_W'(s1_d) << 1);
    case (s1_dom)
      DOM_RED:   t = (s1_gb < 0) ? gb_x + $signed({1'b0, d6_c}) : gb_x;
      DOM_GREEN: t = $signed({1'b0, DEN_W'(s1_d) << 1}) + br_x;
      DOM_BLUE:  t = $signed({1'b0, DEN_W'(s1_d) << 2}) + rg_x;
      default:   t = '0;
    endcase
    num_c   = t[DEN_W-1:0];
    sden_c  = (s1_sum <= ONE_S) ? s1_sum[CH_W-1:0] : CH_W'(TWO_ONE_S - s1_sum);
    half_c  = s1_sum[SUM_W-1:1];
    light_c = (half_c > (SUM_W-1)'(ONE)) ? ONE_C : half_c[CH_W-1:0];
  end

  logic [DEN_W-1:0] s2_num, s2_d6;
  logic [CH_W-1:0]  s2_d, s2_sden, s2_light;
  logic             s2_big, s2_gray;

  always_ff @(posedge clk) begin
    if (en[ST_C]) begin
      s2_num   <= num_c;
      s2_d6    <= d6_c;
      s2_d     <= s1_d;
      s2_sden  <= sden_c;
      s2_big   <= s1_sum >= TWO_ONE_S;
      s2_light <= light_c;
      s2_gray  <= s1_gray;
    end
  end

  // stage D: saturation forced to full scale when the divisor is gone or
  // the quotient would not fit
  logic [DEN_W-1:0] s3_num, s3_d6, s3_snum, s3_sden;
  sb_t              s3_sb;

  always_ff @(posedge clk) begin
    if (en[ST_D]) begin
      s3_num  <= s2_num;
      s3_d6   <= s2_d6;
      s3_snum <= DEN_W'(s2_d);
      s3_sden <= DEN_W'(s2_sden);
      s3_sb.gray      <= s2_gray;
      s3_sb.sat_force <= s2_big || ({1'b0, s2_d} >= {s2_sden, 1'b0});
      s3_sb.light     <= s2_light;
    end
  end

  // dividers
  logic [Q_W-1:0] hue_q, sat_q;

  rhsl_div u_hue_div (
    .clk (clk),
    .en  (en[ST_DIV0 +: DIV_STEPS]),
    .num (s3_num),
    .den (s3_d6),
    .quo (hue_q)
  );

  rhsl_div u_sat_div (
    .clk (clk),
    .en  (en[ST_DIV0 +: DIV_STEPS]),
    .num (s3_snum),
    .den (s3_sden),
    .quo (sat_q)
  );

  sb_t sb [DIV_STEPS];

  always_ff @(posedge clk) begin
    if (en[ST_DIV0]) sb[0] <= s3_sb;
    for (int j = 1; j < DIV_STEPS; j++) begin
      if (en[ST_DIV0+j]) sb[j] <= sb[j-1];
    end
  end

  // output register
  logic [CH_W-1:0] o_hue, o_sat, o_light;
  sb_t             sb_last;

  assign sb_last = sb[DIV_STEPS-1];

  always_ff @(posedge clk) begin
    if (en[ST_OUT]) begin
      if (sb_last.gray) begin
        o_hue <= '0;
        o_sat <= '0;
      end else begin
        o_hue <= (hue_q > ONE_C) ? ONE_C : hue_q;
        o_sat <= (sb_last.sat_force || sat_q > ONE_C) ? ONE_C : sat_q;
      end
      o_light <= sb_last.light;
    end
  end

  assign hsl.valid      = v[ST_OUT];
  assign hsl.hue        = o_hue;
  assign hsl.saturation = o_sat;
  assign hsl.lightness  = o_light;

endmodule
